[design/tcrp_pkg.sv]
// ----------------------------------------------------------------------------
// tcrp_pkg
// Shared types, character codes and limits for the STAT reply line parser.
// ----------------------------------------------------------------------------
package tcrp_pkg;

    localparam int CountWidth = 64;
    localparam int LenWidth   = 6;

    localparam logic [LenWidth-1:0] BODY_MIN   = 6'd8;
    localparam logic [LenWidth-1:0] BODY_MAX   = 6'd46;
    localparam logic [LenWidth-1:0] LENGTH_CAP = 6'd63;
    localparam logic [LenWidth-1:0] VERB_LEN   = 6'd5;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic                  status;
        logic [CountWidth-1:0] upload_count;
        logic [CountWidth-1:0] download_count;
    } tcrp_result_t;

    // Expected verb text "STAT " by position
    function automatic logic [7:0] verb_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = 8'h53;
            3'd1:    ch = 8'h54;
            3'd2:    ch = 8'h41;
            3'd3:    ch = 8'h54;
            3'd4:    ch = CHAR_SPACE;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

[design/tcrp_in_stage.sv]
// ----------------------------------------------------------------------------
// tcrp_in_stage
// Input register: holds one byte transaction until the parser consumes it.
// ----------------------------------------------------------------------------
module tcrp_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_byte,
    input  logic       end_of_line,
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] byte_data,
    output logic       byte_last
);
    logic       in_valid_reg;
    logic       in_valid_next;
    logic [7:0] char_reg;
    logic       eol_reg;
    logic       take;

    // Accept when empty or when the held byte moves on this cycle
    assign in_ready      = !in_valid_reg || advance;
    assign take          = in_valid && in_ready;
    assign in_valid_next = take || (in_valid_reg && !advance);

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Capture the payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            char_reg <= char_byte;
            eol_reg  <= end_of_line;
        end
    end

    assign byte_valid = in_valid_reg;
    assign byte_data  = char_reg;
    assign byte_last  = eol_reg;

endmodule

[design/tcrp_parse.sv]
// ----------------------------------------------------------------------------
// tcrp_parse
// Line state and per-byte parse logic; forms the result on the last byte.
// ----------------------------------------------------------------------------
module tcrp_parse (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            byte_data,
    input  logic                  byte_last,
    output tcrp_pkg::tcrp_result_t result
);
    import tcrp_pkg::*;

    logic [LenWidth-1:0]   len_reg, len_next;
    logic                  which_reg, which_next;
    logic [CountWidth-1:0] first_reg, first_next;
    logic [CountWidth-1:0] second_reg, second_next;
    logic                  seen_reg, seen_next;
    logic                  err_reg, err_next;
    logic                  eol_reg, eol_next;

    logic [CountWidth-1:0] cur_value;
    logic [CountWidth+3:0] wide_value;
    logic [CountWidth+3:0] scaled;
    logic [CountWidth+3:0] digit_ext;
    logic                  overflow;
    logic                  is_digit;
    logic                  is_break;
    logic                  ok;

    // Times ten plus digit, with four guard bits to catch overflow
    assign cur_value  = which_reg ? second_reg : first_reg;
    assign wide_value = {4'b0000, cur_value};
    assign digit_ext  = {{(CountWidth){1'b0}}, byte_data[3:0]};
    assign scaled     = (wide_value << 3) + (wide_value << 1) + digit_ext;
    assign overflow   = |scaled[CountWidth+3:CountWidth];
    assign is_digit   = (byte_data >= CHAR_ZERO) && (byte_data <= CHAR_NINE);
    assign is_break   = (byte_data == CHAR_CR) || (byte_data == CHAR_LF);

    // Advance the line state by one byte
    always_comb
    begin
        len_next    = len_reg;
        which_next  = which_reg;
        first_next  = first_reg;
        second_next = second_reg;
        seen_next   = seen_reg;
        err_next    = err_reg;
        eol_next    = eol_reg;
        if (!err_reg)
        begin
            if (is_break)
            begin
                eol_next = 1'b1;
            end
            else if (eol_reg)
            begin
                err_next = 1'b1;
            end
            else
            begin
                if (len_reg != LENGTH_CAP)
                begin
                    len_next = len_reg + 6'd1;
                end
                if (len_reg < VERB_LEN)
                begin
                    if (byte_data != verb_char(len_reg[2:0]))
                    begin
                        err_next = 1'b1;
                    end
                end
                else if (is_digit)
                begin
                    if (overflow)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        if (which_reg)
                        begin
                            second_next = scaled[CountWidth-1:0];
                        end
                        else
                        begin
                            first_next = scaled[CountWidth-1:0];
                        end
                        seen_next = 1'b1;
                    end
                end
                else if ((byte_data == CHAR_SPACE) && !which_reg && seen_reg)
                begin
                    which_next = 1'b1;
                    seen_next  = 1'b0;
                end
                else
                begin
                    err_next = 1'b1;
                end
            end
        end
    end

    // Form the result from the updated state
    assign ok = !err_next && which_next && seen_next &&
                (len_next >= BODY_MIN) && (len_next <= BODY_MAX);

    always_comb
    begin
        result.status         = ok ? STATUS_OK : STATUS_ERR;
        result.upload_count   = ok ? first_next : '0;
        result.download_count = ok ? second_next : '0;
    end

    // Update the line state; clear after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= '0;
            which_reg  <= 1'b0;
            first_reg  <= '0;
            second_reg <= '0;
            seen_reg   <= 1'b0;
            err_reg    <= 1'b0;
            eol_reg    <= 1'b0;
        end
        else if (step && byte_last)
        begin
            len_reg    <= '0;
            which_reg  <= 1'b0;
            first_reg  <= '0;
            second_reg <= '0;
            seen_reg   <= 1'b0;
            err_reg    <= 1'b0;
            eol_reg    <= 1'b0;
        end
        else if (step)
        begin
            len_reg    <= len_next;
            which_reg  <= which_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            seen_reg   <= seen_next;
            err_reg    <= err_next;
            eol_reg    <= eol_next;
        end
    end

endmodule

[design/tcrp_out_stage.sv]
// ----------------------------------------------------------------------------
// tcrp_out_stage
// Result register: holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
module tcrp_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  tcrp_pkg::tcrp_result_t result,
    output logic                  slot_free,
    output logic                  out_valid,
    input  logic                  out_ready,
    output tcrp_pkg::tcrp_result_t held
);
    import tcrp_pkg::*;

    logic         out_valid_reg;
    logic         out_valid_next;
    tcrp_result_t result_reg;

    assign slot_free      = !out_valid_reg || out_ready;
    assign out_valid_next = load || (out_valid_reg && !out_ready);

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the result
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign held      = result_reg;

endmodule

[design/two_counter_reply_parser.sv]
// ----------------------------------------------------------------------------
// two_counter_reply_parser
// Parses a "STAT <n> <m>" reply line byte by byte into two 64-bit counts.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  input   | in_valid / in_ready  | char_byte[7:0], end_of_line
//  output  | out_valid / out_ready| status, upload_count[63:0], download_count
//
//  One byte per cycle sustained unless a last byte waits on a full result
//  register; a byte passes the input register, then the times-ten-plus-digit
//  step and the line checks in the cycle it leaves that register. A result
//  enters the result register at the edge its last byte leaves the input register.
//  Reset clears the line state and both valid flags.
//  A stalled result holds the last byte of the next line in the input register,
//  which then stalls the input; earlier bytes keep flowing while the result waits.
// ----------------------------------------------------------------------------
module two_counter_reply_parser (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [7:0]                      char_byte,
    input  logic                            end_of_line,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            status,
    output logic [tcrp_pkg::CountWidth-1:0] upload_count,
    output logic [tcrp_pkg::CountWidth-1:0] download_count
);
    import tcrp_pkg::*;

    logic         byte_valid;
    logic [7:0]   byte_data;
    logic         byte_last;
    logic         advance;
    logic         load;
    logic         slot_free;
    tcrp_result_t result;
    tcrp_result_t held;

    // Move a byte on unless it is a last byte facing a full result register
    assign advance = byte_valid && (!byte_last || slot_free);
    assign load    = advance && byte_last;

    tcrp_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .char_byte   (char_byte),
        .end_of_line (end_of_line),
        .advance     (advance),
        .byte_valid  (byte_valid),
        .byte_data   (byte_data),
        .byte_last   (byte_last)
    );

    tcrp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .byte_data (byte_data),
        .byte_last (byte_last),
        .result    (result)
    );

    tcrp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .result    (result),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .held      (held)
    );

    assign status         = held.status;
    assign upload_count   = held.upload_count;
    assign download_count = held.download_count;

    // A result is loaded only into a free or draining result register
    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> slot_free)
        else $error("result loaded over a pending transaction");

    // An error result carries zero counts
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STATUS_ERR)) |->
            ((upload_count == '0) && (download_count == '0)))
        else $error("error result with nonzero counts");

    // A byte that does not end the line never stalls the input
    assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && !byte_last) |-> in_ready)
        else $error("input stalled on a mid-line byte");

    // A loaded result shows as valid on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid)
        else $error("loaded result not presented");

endmodule
